>>> hdl/tep_pkg.sv
`default_nettype none
package tep_pkg;

  // table geometry
  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // purge list cap under pressure; not below CAP_MIN_COUNT, so a cut list
  // always holds more than CAP_MIN_COUNT entries
  localparam int PURGE_CAP     = 50;
  localparam int CAP_MIN_COUNT = 10;
  localparam int FREQ_USES     = 100;
  localparam int FREQ_GRACE    = 30;
  localparam int FORCE_MIN_AGE = 10;

  // sum of freed sizes during one cleanup
  localparam int FREED_W = 32 + CNT_W;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_MARK  = 3'd1,
    REQ_REG   = 3'd2,
    REQ_UNREG = 3'd3,
    REQ_PURGE = 3'd4,
    REQ_CLEAN = 3'd5,
    REQ_USAGE = 3'd6
  } req_e_t;

  localparam logic [2:0] CFG_UNUSED_THR = 3'd0;
  localparam logic [2:0] CFG_AGGR_THR   = 3'd1;
  localparam logic [2:0] CFG_AGGR_ON    = 3'd2;
  localparam logic [2:0] CFG_PRESSURE   = 3'd3;
  localparam logic [2:0] CFG_TARGET     = 3'd4;

  typedef struct packed {
    logic [31:0] size;
    logic [31:0] last;
    logic [31:0] uses;
    logic        rt;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_RMW     = 7'b0000010,
    S_FINISH  = 7'b0000100,
    S_SCAN    = 7'b0001000,
    S_PICK    = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT_WR = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

>>> hdl/tep_if.sv
`default_nettype none
interface tep_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [5:0]  slot;
  logic [31:0] surf_bytes;
  logic        render_target;
  logic [15:0] free_goal_mb;
  logic [47:0] usage_bytes;
  modport source (output valid, req_type, slot, surf_bytes, render_target,
                  free_goal_mb, usage_bytes, input ready);
  modport sink (input valid, req_type, slot, surf_bytes, render_target,
                free_goal_mb, usage_bytes, output ready);
endinterface

interface tep_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  out_slot;
  logic        out_valid;
  logic        out_last;
  logic [6:0]  entry_count;
  logic [27:0] usage_mb;
  logic [31:0] purged_count;
  logic [27:0] freed_mb;
  logic [31:0] frame_now;
  modport source (output valid, out_slot, out_valid, out_last, entry_count, usage_mb,
                  purged_count, freed_mb, frame_now, input ready);
  modport sink (input valid, out_slot, out_valid, out_last, entry_count, usage_mb,
                purged_count, freed_mb, frame_now, output ready);
endinterface

interface tep_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [27:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/tep_ram.sv
`default_nettype none
module tep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/texture_eviction_policy.sv
`default_nettype none
// Surface eviction policy.
// in_ch takes one request beat at a time (tick, mark used, register,
// unregister, purge scan, forced cleanup, set usage); ready is high only
// while no request is in progress. cfg_ch writes the threshold and pressure
// registers and is always ready. out_ch returns one or more result beats
// per request, each carrying the current statistics; out_last marks the
// final beat. An output register parts the two sides: a finished single
// result may wait on out_ch while the next request is taken.
// Tick, register and set usage go straight from idle to the finish state;
// mark used and unregister of a valid slot add a read-modify-write state.
// A purge scan or cleanup walks the entry memory once per selected slot,
// plus a last walk when it runs out of candidates, then reads each listed
// beat from the pick memory; the entry memory has a single read port.
// Reset clears the valid bits, counters and statistics and loads the
// register defaults; no clearing pass is needed.
// When out_ch stalls the block holds the result and stops at its next result.
module texture_eviction_policy
  import tep_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst_n,
  tep_in_if.sink     in_ch,
  tep_out_if.source  out_ch,
  tep_cfg_if.sink    cfg_ch
);

  state_t               state_r;
  req_e_t               req_r;
  logic [15:0]          unused_thr_r, aggr_thr_r;
  logic                 aggr_on_r;
  logic [27:0]          pressure_r, target_r;
  logic [SLOTS-1:0]     valid_r, picked_r;
  logic [CNT_W-1:0]     cnt_r, n_r, k_r, ptr_r;
  logic [31:0]          frame_r, purge_r;
  logic [47:0]          usage_r, freed_r;
  logic [15:0]          thr_r;
  logic                 press_r;
  logic [35:0]          goal_r;
  logic [FREED_W-1:0]   acc_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_slot_r, slot_r;
  logic                 have_best_r, best_rt_r;
  logic [IDX_W-1:0]     best_slot_r;
  logic [31:0]          best_size_r, best_uses_r, best_age_r;
  logic                 ovalid_r, o_sel_r, o_last_r;
  logic [5:0]           o_slot_r;
  logic [6:0]           o_cnt_r;
  logic [27:0]          o_usage_r, o_freed_r;
  logic [31:0]          o_purge_r, o_frame_r;

  entry_t               e_rdata, e_wdata;
  logic                 e_we;
  logic [IDX_W-1:0]     e_waddr, e_raddr, in_idx;
  logic [IDX_W-1:0]     p_rdata;
  logic                 in_fire, in_range, out_free, press_now, beat_load;
  logic [31:0]          age;
  logic                 elig, better, take;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_idx       = IDX_W'(in_ch.slot);
  assign in_range     = 32'(in_ch.slot) < SLOTS;
  assign out_free     = !ovalid_r || out_ch.ready;
  assign beat_load    = out_free && (state_r == S_FINISH || state_r == S_EMIT_WR);
  assign press_now    = (usage_r[47:20] > pressure_r) || (usage_r[47:20] > target_r);

  // entry memory ports
  assign e_raddr = (state_r == S_SCAN) ? ptr_r[IDX_W-1:0] : in_idx;
  always_comb begin
    e_we    = 1'b0;
    e_waddr = in_idx;
    e_wdata = e_rdata;
    if (in_fire && req_e_t'(in_ch.req_type) == REQ_REG && in_range) begin
      e_we    = 1'b1;
      e_wdata = '{size: in_ch.surf_bytes, last: frame_r, uses: 32'd1,
                  rt: in_ch.render_target};
    end else if (state_r == S_RMW && req_r == REQ_MARK) begin
      e_we    = 1'b1;
      e_waddr = slot_r;
      e_wdata.last = frame_r;
      e_wdata.uses = (e_rdata.uses == '1) ? e_rdata.uses : e_rdata.uses + 32'd1;
    end
  end

  tep_ram #(.WIDTH($bits(entry_t)), .DEPTH(SLOTS)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  tep_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_pick_ram (
    .clk   (clk),
    .we    (state_r == S_PICK && have_best_r),
    .waddr (n_r[IDX_W-1:0]),
    .wdata (best_slot_r),
    .raddr (k_r[IDX_W-1:0]),
    .rdata (p_rdata)
  );

  // grace rules and ordering for the entry read back this cycle
  assign age = frame_r - e_rdata.last;
  always_comb begin
    if (req_r == REQ_CLEAN) begin
      elig   = !e_rdata.rt && (age > 32'(FORCE_MIN_AGE));
      better = age > best_age_r;
    end else begin
      if (age < 32'(thr_r)) begin
        elig = 1'b0;
      end else if (e_rdata.rt) begin
        elig = age > {15'd0, thr_r, 1'b0};
      end else if (e_rdata.uses > 32'(FREQ_USES)) begin
        elig = age > (32'(thr_r) + 32'(FREQ_GRACE));
      end else if (press_r) begin
        elig = age > 32'(thr_r >> 1);
      end else begin
        elig = 1'b1;
      end
      better = (!e_rdata.rt && best_rt_r) ||
               ((e_rdata.rt == best_rt_r) &&
                ((e_rdata.size > best_size_r) ||
                 ((e_rdata.size == best_size_r) && (e_rdata.uses < best_uses_r))));
    end
    take = rd_vld_r && valid_r[rd_slot_r] && !picked_r[rd_slot_r] && elig &&
           (!have_best_r || better);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      cnt_r        <= '0;
      n_r          <= '0;
      frame_r      <= '0;
      usage_r      <= '0;
      purge_r      <= '0;
      freed_r      <= '0;
      ovalid_r     <= 1'b0;
      rd_vld_r     <= 1'b0;
      unused_thr_r <= 16'd60;
      aggr_thr_r   <= 16'd30;
      aggr_on_r    <= 1'b0;
      pressure_r   <= 28'd2048;
      target_r     <= 28'd4096;
    end else begin
      // register writes
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_UNUSED_THR: unused_thr_r <= cfg_ch.data[15:0];
          CFG_AGGR_THR:   aggr_thr_r   <= cfg_ch.data[15:0];
          CFG_AGGR_ON:    aggr_on_r    <= cfg_ch.data[0];
          CFG_PRESSURE:   pressure_r   <= cfg_ch.data;
          CFG_TARGET:     target_r     <= cfg_ch.data;
          default: ;
        endcase
      end

      // load a new output beat, or drop the current one once taken
      if (beat_load) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      rd_vld_r <= (state_r == S_SCAN) && (ptr_r < CNT_W'(SLOTS));

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            req_r       <= req_e_t'(in_ch.req_type);
            slot_r      <= in_idx;
            n_r         <= '0;
            k_r         <= '0;
            ptr_r       <= '0;
            picked_r    <= '0;
            have_best_r <= 1'b0;
            acc_r       <= '0;
            goal_r      <= {in_ch.free_goal_mb, 20'd0};
            press_r     <= press_now;
            thr_r       <= (aggr_on_r && press_now) ? aggr_thr_r : unused_thr_r;
            case (req_e_t'(in_ch.req_type))
              REQ_TICK: begin
                frame_r <= frame_r + 32'd1;
                state_r <= S_FINISH;
              end
              REQ_MARK, REQ_UNREG: begin
                state_r <= (in_range && valid_r[in_idx]) ? S_RMW : S_FINISH;
              end
              REQ_REG: begin
                if (in_range) begin
                  if (!valid_r[in_idx]) begin
                    cnt_r <= cnt_r + CNT_W'(1);
                  end
                  valid_r[in_idx] <= 1'b1;
                  usage_r <= usage_r + 48'(in_ch.surf_bytes);
                end
                state_r <= S_FINISH;
              end
              REQ_PURGE: state_r <= S_SCAN;
              REQ_CLEAN: begin
                state_r <= (in_ch.free_goal_mb != 16'd0) ? S_SCAN : S_FINISH;
              end
              REQ_USAGE: begin
                usage_r <= in_ch.usage_bytes;
                state_r <= S_FINISH;
              end
              default: state_r <= S_FINISH;
            endcase
          end
        end

        S_RMW: begin
          // mark used writes the entry back through the memory port
          if (req_r == REQ_UNREG) begin
            usage_r         <= usage_r - 48'(e_rdata.size);
            valid_r[slot_r] <= 1'b0;
            cnt_r           <= cnt_r - CNT_W'(1);
          end
          state_r <= S_FINISH;
        end

        S_SCAN: begin
          // issue reads, then track the best candidate as data returns
          if (ptr_r < CNT_W'(SLOTS)) begin
            rd_slot_r <= ptr_r[IDX_W-1:0];
            ptr_r     <= ptr_r + CNT_W'(1);
          end else if (!rd_vld_r) begin
            state_r <= S_PICK;
          end
          if (take) begin
            have_best_r <= 1'b1;
            best_slot_r <= rd_slot_r;
            best_size_r <= e_rdata.size;
            best_uses_r <= e_rdata.uses;
            best_rt_r   <= e_rdata.rt;
            best_age_r  <= age;
          end
        end

        S_PICK: begin
          ptr_r       <= '0;
          have_best_r <= 1'b0;
          if (!have_best_r) begin
            state_r <= (n_r == '0) ? S_FINISH : S_EMIT_RD;
          end else begin
            n_r                   <= n_r + CNT_W'(1);
            picked_r[best_slot_r] <= 1'b1;
            if (req_r == REQ_CLEAN) begin
              acc_r                <= acc_r + FREED_W'(best_size_r);
              usage_r              <= usage_r - 48'(best_size_r);
              valid_r[best_slot_r] <= 1'b0;
              cnt_r                <= cnt_r - CNT_W'(1);
              state_r <= ((acc_r + FREED_W'(best_size_r)) >= FREED_W'(goal_r)) ?
                         S_EMIT_RD : S_SCAN;
            end else begin
              purge_r <= purge_r + 32'd1;
              freed_r <= freed_r + 48'(best_size_r);
              state_r <= (press_r && (n_r + CNT_W'(1)) == CNT_W'(PURGE_CAP)) ?
                         S_EMIT_RD : S_SCAN;
            end
          end
        end

        S_EMIT_RD: state_r <= S_EMIT_WR;

        S_EMIT_WR: begin
          if (out_free) begin
            o_slot_r <= 6'(p_rdata);
            o_sel_r  <= 1'b1;
            o_last_r <= (k_r + CNT_W'(1)) == n_r;
            k_r      <= k_r + CNT_W'(1);
            state_r  <= ((k_r + CNT_W'(1)) == n_r) ? S_IDLE : S_EMIT_RD;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            o_slot_r <= '0;
            o_sel_r  <= 1'b0;
            o_last_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase

      // snapshot the statistics with every beat
      if (beat_load) begin
        o_cnt_r   <= 7'(cnt_r);
        o_usage_r <= usage_r[47:20];
        o_purge_r <= purge_r;
        o_freed_r <= freed_r[47:20];
        o_frame_r <= frame_r;
      end
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.out_slot     = o_slot_r;
  assign out_ch.out_valid    = o_sel_r;
  assign out_ch.out_last     = o_last_r;
  assign out_ch.entry_count  = o_cnt_r;
  assign out_ch.usage_mb     = o_usage_r;
  assign out_ch.purged_count = o_purge_r;
  assign out_ch.freed_mb     = o_freed_r;
  assign out_ch.frame_now    = o_frame_r;

  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == $countones(valid_r))
    else $error("entry count differs from valid bits");

  a_pick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(SLOTS))
    else $error("pick count beyond table size");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !o_sel_r |-> o_last_r)
    else $error("empty result not marked last");

  a_cap_kept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT_WR && req_r == REQ_PURGE && press_r |-> n_r <= CNT_W'(PURGE_CAP))
    else $error("purge list over cap under pressure");

endmodule
`default_nettype wire

>>> tb/sv/texture_eviction_policy_tb.sv
`timescale 1ns / 1ps
module texture_eviction_policy_tb;
  import tep_pkg::*;

  localparam logic [2:0] REQ_NONE = 3'd7;    // undefined request code
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 400;

  // one request row; the chk_* columns carry values typed in by hand
  typedef struct packed {
    logic [2:0]  req;
    logic [5:0]  slot;
    logic [31:0] size;
    logic        rt;
    logic [15:0] goal;
    logic [47:0] usage;
    logic        chk;
    logic        chk_listed;
    logic [6:0]  chk_count;
    logic [31:0] chk_frame;
  } req_row_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic        listed;
    logic        last;
    logic [6:0]  count;
    logic [27:0] usage_mb;
    logic [31:0] purged;
    logic [27:0] freed_mb;
    logic [31:0] frame;
  } beat_t;

  logic clk;
  logic rst_n;

  tep_in_if  in_ch ();
  tep_out_if out_ch ();
  tep_cfg_if cfg_ch ();

  texture_eviction_policy u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // shadow of the block's registers and table
  logic [15:0] sh_unused_thr;
  logic [15:0] sh_aggr_thr;
  logic        sh_aggr_on;
  logic [27:0] sh_pressure_mb;
  logic [27:0] sh_target_mb;
  logic        tab_valid [SLOTS];
  logic [31:0] tab_size  [SLOTS];
  logic [31:0] tab_last  [SLOTS];
  logic [31:0] tab_uses  [SLOTS];
  logic        tab_rt    [SLOTS];
  logic [31:0] frame_cnt;
  logic [47:0] usage_sum;
  logic [31:0] purge_sum;
  logic [47:0] freed_sum;
  int          picks [SLOTS];

  beat_t       pending_beats[$];
  int          errors;
  int          beats_seen;
  int          reqs_sent;
  int          listed_seen;
  longint      cycles;
  bit          calm;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
        $display("texture_eviction_policy_tb: errors");
        $finish;
      end
    end
  end

  function automatic bit pressure_now();
    logic [27:0] mb;
    mb = usage_sum[47:20];
    return (mb > sh_pressure_mb) || (mb > sh_target_mb);
  endfunction

  function automatic bit purge_first(int a, int b);
    if (tab_rt[a] != tab_rt[b]) return !tab_rt[a];
    if (tab_size[a] != tab_size[b]) return tab_size[a] > tab_size[b];
    if (tab_uses[a] != tab_uses[b]) return tab_uses[a] < tab_uses[b];
    return a < b;
  endfunction

  function automatic bit older_first(int a, int b);
    logic [31:0] age_a;
    logic [31:0] age_b;
    age_a = frame_cnt - tab_last[a];
    age_b = frame_cnt - tab_last[b];
    if (age_a != age_b) return age_a > age_b;
    return a < b;
  endfunction

  function automatic void sort_picks(int n, bit by_purge);
    int v;
    int j;
    for (int i = 1; i < n; i++) begin
      v = picks[i];
      j = i;
      while (j > 0 && (by_purge ? purge_first(v, picks[j-1]) : older_first(v, picks[j-1])))
      begin
        picks[j] = picks[j-1];
        j--;
      end
      picks[j] = v;
    end
  endfunction

  function automatic void drop_entry(int s);
    usage_sum = usage_sum - {16'd0, tab_size[s]};
    tab_valid[s] = 1'b0;
  endfunction

  // apply one request to the shadow and queue the beats it yields
  function automatic beat_t predict_beats(req_row_t r);
    int          s;
    int          n;
    int          m;
    int          cnt;
    logic [15:0] thr;
    logic [31:0] age;
    bit          press;
    bit          ok;
    logic [63:0] goal;
    logic [63:0] got;
    beat_t       b;
    beat_t       first;
    s = r.slot;
    n = 0;
    case (r.req)
      REQ_TICK: frame_cnt++;
      REQ_MARK: begin
        if (tab_valid[s]) begin
          tab_last[s] = frame_cnt;
          if (tab_uses[s] != 32'hFFFF_FFFF) tab_uses[s]++;
        end
      end
      REQ_REG: begin
        tab_valid[s] = 1'b1;
        tab_size[s]  = r.size;
        tab_last[s]  = frame_cnt;
        tab_rt[s]    = r.rt;
        tab_uses[s]  = 1;
        usage_sum    = usage_sum + {16'd0, r.size};
      end
      REQ_UNREG: if (tab_valid[s]) drop_entry(s);
      REQ_PURGE: begin
        press = pressure_now();
        thr = (sh_aggr_on && press) ? sh_aggr_thr : sh_unused_thr;
        for (int i = 0; i < SLOTS; i++) begin
          if (tab_valid[i]) begin
            age = frame_cnt - tab_last[i];
            if (age < {16'd0, thr}) ok = 0;
            else if (tab_rt[i]) ok = age > {15'd0, thr, 1'b0};
            else if (tab_uses[i] > FREQ_USES) ok = age > ({16'd0, thr} + FREQ_GRACE);
            else if (press) ok = age > {17'd0, thr[15:1]};
            else ok = 1;
            if (ok) begin
              picks[n] = i;
              n++;
            end
          end
        end
        sort_picks(n, 1);
        if (press && n > CAP_MIN_COUNT && n > PURGE_CAP) n = PURGE_CAP;
        for (int i = 0; i < n; i++) begin
          purge_sum++;
          freed_sum = freed_sum + {16'd0, tab_size[picks[i]]};
        end
      end
      REQ_CLEAN: begin
        m = 0;
        got = 0;
        goal = {48'd0, r.goal} << 20;
        for (int i = 0; i < SLOTS; i++)
          if (tab_valid[i] && !tab_rt[i] && (frame_cnt - tab_last[i]) > FORCE_MIN_AGE) begin
            picks[m] = i;
            m++;
          end
        sort_picks(m, 0);
        for (int i = 0; i < m; i++) begin
          if (got >= goal) break;
          got += tab_size[picks[i]];
          drop_entry(picks[i]);
          n++;
        end
      end
      REQ_USAGE: usage_sum = r.usage;
      default: ;
    endcase
    cnt = 0;
    for (int i = 0; i < SLOTS; i++) if (tab_valid[i]) cnt++;
    for (int k = 0; k < ((n == 0) ? 1 : n); k++) begin
      b.slot     = (n == 0) ? 6'd0 : picks[k][5:0];
      b.listed   = (n != 0);
      b.last     = (k == ((n == 0) ? 0 : n - 1));
      b.count    = cnt[6:0];
      b.usage_mb = usage_sum[47:20];
      b.purged   = purge_sum;
      b.freed_mb = freed_sum[47:20];
      b.frame    = frame_cnt;
      if (k == 0) first = b;
      pending_beats = {pending_beats, b};
    end
    return first;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // compare each result beat with the oldest pending one
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, slot %0d", $time, out_ch.out_slot);
        errors++;
      end else begin
        e = pending_beats.pop_front();
        if (e.listed) listed_seen++;
        check_field("out_slot", e.slot, out_ch.out_slot);
        check_field("out_valid", e.listed, out_ch.out_valid);
        check_field("out_last", e.last, out_ch.out_last);
        check_field("entry_count", e.count, out_ch.entry_count);
        check_field("usage_mb", e.usage_mb, out_ch.usage_mb);
        check_field("purged_count", e.purged, out_ch.purged_count);
        check_field("freed_mb", e.freed_mb, out_ch.freed_mb);
        check_field("frame_now", e.frame, out_ch.frame_now);
      end
    end
  end

  // result side: random stalls, or one long hold when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // valid stays high across back-to-back writes; set_regs drops it
  task automatic write_reg(logic [2:0] idx, logic [27:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_UNUSED_THR: sh_unused_thr  = val[15:0];
      CFG_AGGR_THR:   sh_aggr_thr    = val[15:0];
      CFG_AGGR_ON:    sh_aggr_on     = val[0];
      CFG_PRESSURE:   sh_pressure_mb = val;
      CFG_TARGET:     sh_target_mb   = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] thr, logic [15:0] athr, logic on,
                          logic [27:0] pmb, logic [27:0] tmb);
    write_reg(CFG_UNUSED_THR, {12'd0, thr});
    write_reg(CFG_AGGR_THR, {12'd0, athr});
    write_reg(CFG_AGGR_ON, {27'd0, on});
    write_reg(CFG_PRESSURE, pmb);
    write_reg(CFG_TARGET, tmb);
    cfg_ch.valid <= 1'b0;
  endtask

  // send one request beat, outside calm phases sometimes with a random gap in front of it
  task automatic send_req(req_row_t r);
    beat_t first;
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= r.req;
    in_ch.slot          <= r.slot;
    in_ch.surf_bytes    <= r.size;
    in_ch.render_target <= r.rt;
    in_ch.free_goal_mb  <= r.goal;
    in_ch.usage_bytes   <= r.usage;
    do @(posedge clk); while (!in_ch.ready);
    reqs_sent++;
    first = predict_beats(r);
    if (r.chk && (first.listed !== r.chk_listed || first.count !== r.chk_count ||
                  first.frame !== r.chk_frame)) begin
      $display("%0t: typed row mismatch, expected listed %0b count %0d frame %0d, got %0b %0d %0d",
               $time, r.chk_listed, r.chk_count, r.chk_frame,
               first.listed, first.count, first.frame);
      errors++;
    end
  endtask

  // hold off until every pending beat is back, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic req_row_t mk(logic [2:0] req, logic [5:0] slot, logic [31:0] size,
                                  logic rt, logic [15:0] goal, logic [47:0] usage);
    req_row_t r;
    r = '0;
    r.req = req; r.slot = slot; r.size = size; r.rt = rt; r.goal = goal; r.usage = usage;
    return r;
  endfunction

  function automatic req_row_t mk_chk(logic [2:0] req, logic [5:0] slot, logic [31:0] size,
                                      logic rt, logic [15:0] goal, logic [47:0] usage,
                                      logic listed, logic [6:0] cnt, logic [31:0] frame);
    req_row_t r;
    r = mk(req, slot, size, rt, goal, usage);
    r.chk = 1'b1; r.chk_listed = listed; r.chk_count = cnt; r.chk_frame = frame;
    return r;
  endfunction

  function automatic req_row_t random_req();
    int          w;
    logic [2:0]  req;
    logic [15:0] goal;
    w = $urandom_range(0, 99);
    if (w < 28)      req = REQ_REG;
    else if (w < 55) req = REQ_TICK;
    else if (w < 68) req = REQ_MARK;
    else if (w < 76) req = REQ_UNREG;
    else if (w < 84) req = REQ_PURGE;
    else if (w < 90) req = REQ_CLEAN;
    else if (w < 97) req = REQ_USAGE;
    else             req = REQ_NONE;
    goal = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 8));
    return mk(req, 6'($urandom_range(0, SLOTS - 1)),
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0400_0000),
              $urandom_range(0, 3) == 0, goal, 48'({$urandom, $urandom}));
  endfunction

  req_row_t dir_tab [20];

  initial begin
    errors = 0; beats_seen = 0; reqs_sent = 0; listed_seen = 0;
    calm = 0; hold_req = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.req_type = '0; in_ch.slot = '0; in_ch.surf_bytes = '0;
    in_ch.render_target = 1'b0; in_ch.free_goal_mb = '0; in_ch.usage_bytes = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    sh_unused_thr = 60; sh_aggr_thr = 30; sh_aggr_on = 0;
    sh_pressure_mb = 2048; sh_target_mb = 4096;
    for (int i = 0; i < SLOTS; i++) begin
      tab_valid[i] = 0; tab_size[i] = 0; tab_last[i] = 0; tab_uses[i] = 0; tab_rt[i] = 0;
      picks[i] = 0;
    end
    frame_cnt = 0; usage_sum = 0; purge_sum = 0; freed_sum = 0;

    // directed rows, reset settings
    dir_tab[0]  = mk_chk(REQ_TICK,  6'd0,  32'd0,          0, 16'd0, 48'd0, 0, 7'd0, 32'd1);
    dir_tab[1]  = mk_chk(REQ_REG,   6'd0,  32'hFFFF_FFFF,  0, 16'd0, 48'd0, 0, 7'd1, 32'd1);
    dir_tab[2]  = mk_chk(REQ_REG,   6'd63, 32'd0,          1, 16'd0, 48'd0, 0, 7'd2, 32'd1);
    dir_tab[3]  = mk_chk(REQ_MARK,  6'd0,  32'd0,          0, 16'd0, 48'd0, 0, 7'd2, 32'd1);
    dir_tab[4]  = mk_chk(REQ_MARK,  6'd5,  32'd0,          0, 16'd0, 48'd0, 0, 7'd2, 32'd1);
    dir_tab[5]  = mk_chk(REQ_UNREG, 6'd5,  32'd0,          0, 16'd0, 48'd0, 0, 7'd2, 32'd1);
    dir_tab[6]  = mk_chk(REQ_NONE,  6'd63, 32'hFFFF_FFFF,  1, 16'hFFFF, {48{1'b1}},
                         0, 7'd2, 32'd1);
    dir_tab[7]  = mk(REQ_USAGE, 6'd0,  32'd0,          0, 16'd0, {48{1'b1}});
    dir_tab[8]  = mk_chk(REQ_PURGE, 6'd0,  32'd0,          0, 16'd0, 48'd0, 0, 7'd2, 32'd1);
    dir_tab[9]  = mk_chk(REQ_CLEAN, 6'd0,  32'd0,          0, 16'hFFFF, 48'd0, 0, 7'd2, 32'd1);
    dir_tab[10] = mk(REQ_USAGE, 6'd0,  32'd0,          0, 16'd0, 48'd0);
    dir_tab[11] = mk(REQ_REG,   6'd10, 32'h1000_0000,  0, 16'd0, 48'd0);
    dir_tab[12] = mk(REQ_REG,   6'd10, 32'h0010_0000,  1, 16'd0, 48'd0);
    dir_tab[13] = mk(REQ_UNREG, 6'd0,  32'd0,          0, 16'd0, 48'd0);
    dir_tab[14] = mk(REQ_CLEAN, 6'd0,  32'd0,          0, 16'd0, 48'd0);
    dir_tab[15] = mk(REQ_USAGE, 6'd0,  32'd0,          0, 16'd0, 48'h1234_5678_9ABC);
    dir_tab[16] = mk(REQ_PURGE, 6'd0,  32'd0,          0, 16'd0, 48'd0);
    dir_tab[17] = mk(REQ_UNREG, 6'd63, 32'd0,          0, 16'd0, 48'd0);
    dir_tab[18] = mk(REQ_TICK,  6'd0,  32'd0,          0, 16'd0, 48'd0);
    dir_tab[19] = mk(REQ_UNREG, 6'd10, 32'd0,          0, 16'd0, 48'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_req(dir_tab[i]);
    drain();

    // fill the table, age it past a low threshold and scan under pressure
    set_regs(16'd3, 16'd1, 1'b1, 28'd0, 28'hFFF_FFFF);
    hold_req = 1;
    for (int i = 0; i < SLOTS; i++)
      send_req(mk(REQ_REG, i[5:0], $urandom_range(32'h0010_0000, 32'h0800_0000),
                  $urandom_range(0, 4) == 0, 16'd0, 48'd0));
    repeat (8) send_req(mk(REQ_TICK, 6'd0, 32'd0, 0, 16'd0, 48'd0));
    send_req(mk(REQ_PURGE, 6'd0, 32'd0, 0, 16'd0, 48'd0));
    repeat (40) send_req(random_req());
    drain();

    // no idling, zero threshold
    calm = 1;
    set_regs(16'd0, 16'hFFFF, 1'b0, 28'hFFF_FFFF, 28'hFFF_FFFF);
    repeat (60) send_req(random_req());
    drain();
    calm = 0;

    set_regs(16'hFFFF, 16'd0, 1'b1, 28'd100, 28'd0);
    repeat (60) send_req(random_req());
    drain();

    set_regs(16'd5, 16'd2, 1'b1, 28'd4096, 28'd8000);
    repeat (75) send_req(random_req());
    drain();

    repeat (50) @(posedge clk);
    $display("%0d requests, %0d result beats (%0d listing a slot), five register settings",
             reqs_sent, beats_seen, listed_seen);
    if (errors == 0) begin
      $display("texture_eviction_policy_tb: clean");
    end else begin
      $display("texture_eviction_policy_tb: errors");
    end
    $finish;
  end

endmodule

>>> texture_eviction_policy.f
hdl/tep_pkg.sv
hdl/tep_if.sv
hdl/tep_ram.sv
hdl/texture_eviction_policy.sv
tb/sv/texture_eviction_policy_tb.sv
